// ----- rtl/carp_pkg.sv -----
// Shared types, constants and saturating helpers for the cascade angle/rate PID unit.
`default_nettype none
package carp_pkg;

  localparam int DATA_W = 32;           // width of every signed Q16.16 value
  localparam int FRAC_W = 16;           // fraction bits
  localparam int GAIN_W = 31;           // width of a register value
  localparam int PROD_W = DATA_W + GAIN_W;       // exact gain*value product
  localparam int DIV_W  = DATA_W + FRAC_W;       // dividend/quotient bits
  localparam int WIDE_W = DIV_W + 1;             // widest intermediate before saturation
  localparam int CNT_W  = $clog2(DIV_W);
  localparam int ADDR_W = 5;            // eight registers at byte addresses 4*i

  localparam logic [GAIN_W-1:0] OUTER_GAIN_RST = '0;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = '0;
  localparam logic [GAIN_W-1:0] INT_GAIN_RST   = '0;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = '0;
  localparam logic [GAIN_W-1:0] TIME_STEP_RST  = 31'd655;
  localparam logic [GAIN_W-1:0] RATE_LIM_RST   = 31'd131072;
  localparam logic [GAIN_W-1:0] INT_LIM_RST    = 31'd65536;
  localparam logic [GAIN_W-1:0] OUT_LIM_RST    = 31'd65536;

  typedef enum logic [2:0] {
    REG_OUTER_GAIN  = 3'd0,
    REG_PROP_GAIN   = 3'd1,
    REG_INT_GAIN    = 3'd2,
    REG_DERIV_GAIN  = 3'd3,
    REG_TIME_STEP   = 3'd4,
    REG_RATE_LIMIT  = 3'd5,
    REG_INT_LIMIT   = 3'd6,
    REG_OUT_LIMIT   = 3'd7
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AERR,
    ST_MOUT,
    ST_RCMD,
    ST_RERR,
    ST_MP,
    ST_P,
    ST_MI,
    ST_IACC,
    ST_MKI,
    ST_I,
    ST_DIFF,
    ST_MD,
    ST_DPROD,
    ST_DIV,
    ST_DFIN,
    ST_SUM1,
    ST_SUM2,
    ST_DONE
  } state_t;

  // Saturate a wide signed value to DATA_W bits.
  function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = $signed({{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
    lo = $signed({{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});
    if (x > hi) begin
      return hi[DATA_W-1:0];
    end else if (x < lo) begin
      return lo[DATA_W-1:0];
    end
    return x[DATA_W-1:0];
  endfunction

  // Clamp to plus or minus a non-negative limit.
  function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [DATA_W-1:0] x,
                                                         input logic [GAIN_W-1:0] lim);
    logic signed [DATA_W:0] xs;
    logic signed [DATA_W:0] lp;
    logic signed [DATA_W:0] ln;
    xs = {x[DATA_W-1], x};
    lp = $signed({2'b00, lim});
    ln = -lp;
    if (xs > lp) begin
      return lp[DATA_W-1:0];
    end else if (xs < ln) begin
      return ln[DATA_W-1:0];
    end
    return x;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cascade_angle_rate_pid_unit.sv -----
// Top level of the cascade angle/rate PID unit: register file, sequencer and shared datapath.
//
// Use: one axis of a cascaded attitude loop in signed Q16.16. Each input word on
// the in_ channel carries an angle setpoint, measured angle, measured rate and a
// clear flag; each output word on the out_ channel carries one actuator command.
// Both channels are valid/ready. Gains, time step and limits sit in eight APB
// registers at byte addresses 4*i; write them only while the unit is idle.
// Timing: in_ready is high only while the sequencer is idle and out of reset. A
// normal word runs the full sequence to out_valid (the derivative division is
// skipped when time_step is zero); a clear word goes straight to the final step.
// One word is worked on at a time, so a new word is taken only once the last
// has left the sequencer. The longest part is the 48-step restoring divider that
// forms the derivative term; the other steps each use the shared multiplier,
// saturating adder, shift/saturate unit or clamp.
// The output register parts the two sides: a new word is taken while a finished
// result still waits; if the receiver stalls the sequencer holds in its final
// step until the output register frees.
// Reset (synchronous, rst_n low) restores register defaults and clears the
// integral, previous error and last output, and drops any pending result.
`default_nettype none
module cascade_angle_rate_pid_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  // input words
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire                               in_clear_state,
  input  wire  signed [carp_pkg::DATA_W-1:0] in_angle_setpoint,
  input  wire  signed [carp_pkg::DATA_W-1:0] in_angle_measured,
  input  wire  signed [carp_pkg::DATA_W-1:0] in_rate_measured,
  // result words
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic signed [carp_pkg::DATA_W-1:0] out_actuator_command,
  // configuration
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [carp_pkg::ADDR_W-1:0]        paddr,
  input  wire  [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import carp_pkg::*;

  // ---------------------------------------------------------------- registers
  logic [GAIN_W-1:0] outer_gain_r, prop_gain_r, int_gain_r, deriv_gain_r;
  logic [GAIN_W-1:0] time_step_r, rate_lim_r, int_lim_r, out_lim_r;
  reg_idx_t          cfg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_gain_r <= OUTER_GAIN_RST;
      prop_gain_r  <= PROP_GAIN_RST;
      int_gain_r   <= INT_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      time_step_r  <= TIME_STEP_RST;
      rate_lim_r   <= RATE_LIM_RST;
      int_lim_r    <= INT_LIM_RST;
      out_lim_r    <= OUT_LIM_RST;
    end else if (cfg_wr) begin
      // keep the low 31 bits of the written word
      case (cfg_idx)
        REG_OUTER_GAIN: outer_gain_r <= pwdata[GAIN_W-1:0];
        REG_PROP_GAIN:  prop_gain_r  <= pwdata[GAIN_W-1:0];
        REG_INT_GAIN:   int_gain_r   <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain_r <= pwdata[GAIN_W-1:0];
        REG_TIME_STEP:  time_step_r  <= pwdata[GAIN_W-1:0];
        REG_RATE_LIMIT: rate_lim_r   <= pwdata[GAIN_W-1:0];
        REG_INT_LIMIT:  int_lim_r    <= pwdata[GAIN_W-1:0];
        REG_OUT_LIMIT:  out_lim_r    <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OUTER_GAIN: prdata = {1'b0, outer_gain_r};
      REG_PROP_GAIN:  prdata = {1'b0, prop_gain_r};
      REG_INT_GAIN:   prdata = {1'b0, int_gain_r};
      REG_DERIV_GAIN: prdata = {1'b0, deriv_gain_r};
      REG_TIME_STEP:  prdata = {1'b0, time_step_r};
      REG_RATE_LIMIT: prdata = {1'b0, rate_lim_r};
      REG_INT_LIMIT:  prdata = {1'b0, int_lim_r};
      REG_OUT_LIMIT:  prdata = {1'b0, out_lim_r};
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- datapath state
  state_t state_r, state_nxt;

  // controller state, cleared by reset
  logic signed [DATA_W-1:0] integ_r, integ_nxt;
  logic signed [DATA_W-1:0] last_err_r, last_err_nxt;
  logic signed [DATA_W-1:0] last_out_r, last_out_nxt;

  // captured input word and working values
  logic signed [DATA_W-1:0] sp_r, sp_nxt, am_r, am_nxt, rm_r, rm_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt;        // angle error, rate command, then error delta
  logic signed [DATA_W-1:0] rerr_r, rerr_nxt;
  logic signed [DATA_W-1:0] p_r, p_nxt;        // proportional term, then p+i
  logic signed [DATA_W-1:0] i_r, i_nxt;
  logic signed [DATA_W-1:0] d_r, d_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [GAIN_W-1:0]        rem_r, rem_nxt;
  logic [DIV_W-1:0]         quo_r, quo_nxt;    // dividend shifts out, quotient shifts in
  logic                     neg_r, neg_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_cmd_r, out_cmd_nxt;

  // shared units
  logic [GAIN_W-1:0]        mul_a;
  logic signed [DATA_W-1:0] mul_b;
  logic signed [2*DATA_W-1:0] mul_full;
  logic signed [DATA_W-1:0] add_a, add_b;
  logic                     add_sub;
  logic signed [DATA_W:0]   add_raw;
  logic signed [DATA_W-1:0] add_sat;
  logic signed [DATA_W-1:0] shf_sat;
  logic signed [DATA_W-1:0] clp_in;
  logic [GAIN_W-1:0]        clp_lim;
  logic signed [DATA_W-1:0] clp_out;
  logic [GAIN_W+1:0]        div_try;
  logic [DATA_W:0]          dmag;
  logic signed [WIDE_W-1:0] qsig;
  logic                     in_acc;
  logic                     out_free;

  assign mul_full = $signed({1'b0, mul_a}) * mul_b;
  assign add_raw  = add_sub ? ({add_a[DATA_W-1], add_a} - {add_b[DATA_W-1], add_b})
                            : ({add_a[DATA_W-1], add_a} + {add_b[DATA_W-1], add_b});
  assign add_sat  = sat_wide({{(WIDE_W-DATA_W-1){add_raw[DATA_W]}}, add_raw});
  // floor shift of the product, then saturate
  assign shf_sat  = sat_wide({{(WIDE_W-PROD_W+FRAC_W){prod_r[PROD_W-1]}},
                              prod_r[PROD_W-1:FRAC_W]});
  assign clp_out  = clamp_sym(clp_in, clp_lim);
  // one restoring division step
  assign div_try  = {1'b0, rem_r, quo_r[DIV_W-1]} - {2'b00, time_step_r};
  assign dmag     = shf_sat[DATA_W-1] ? (-{shf_sat[DATA_W-1], shf_sat})
                                      : {1'b0, shf_sat};
  assign qsig     = neg_r ? (-$signed({1'b0, quo_r})) : $signed({1'b0, quo_r});

  assign in_ready = rst_n && (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid            = out_valid_r;
  assign out_actuator_command = out_cmd_r;

  always_comb begin
    state_nxt     = state_r;
    integ_nxt     = integ_r;
    last_err_nxt  = last_err_r;
    last_out_nxt  = last_out_r;
    sp_nxt        = sp_r;
    am_nxt        = am_r;
    rm_nxt        = rm_r;
    x_nxt         = x_r;
    rerr_nxt      = rerr_r;
    p_nxt         = p_r;
    i_nxt         = i_r;
    d_nxt         = d_r;
    prod_nxt      = prod_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cmd_nxt   = out_cmd_r;
    mul_a         = '0;
    mul_b         = '0;
    add_a         = '0;
    add_b         = '0;
    add_sub       = 1'b0;
    clp_in        = '0;
    clp_lim       = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sp_nxt = in_angle_setpoint;
          am_nxt = in_angle_measured;
          rm_nxt = in_rate_measured;
          if (in_clear_state) begin
            // drop the loop state; the result is zero
            integ_nxt    = '0;
            last_err_nxt = '0;
            last_out_nxt = '0;
            state_nxt    = ST_DONE;
          end else begin
            state_nxt = ST_AERR;
          end
        end
      end
      ST_AERR: begin
        add_a     = sp_r;
        add_b     = am_r;
        add_sub   = 1'b1;
        x_nxt     = add_sat;
        state_nxt = ST_MOUT;
      end
      ST_MOUT: begin
        mul_a     = outer_gain_r;
        mul_b     = x_r;
        prod_nxt  = $signed(mul_full[PROD_W-1:0]);
        state_nxt = ST_RCMD;
      end
      ST_RCMD: begin
        clp_in    = shf_sat;
        clp_lim   = rate_lim_r;
        x_nxt     = clp_out;
        state_nxt = ST_RERR;
      end
      ST_RERR: begin
        add_a     = x_r;
        add_b     = rm_r;
        add_sub   = 1'b1;
        rerr_nxt  = add_sat;
        state_nxt = ST_MP;
      end
      ST_MP: begin
        mul_a     = prop_gain_r;
        mul_b     = rerr_r;
        prod_nxt  = $signed(mul_full[PROD_W-1:0]);
        state_nxt = ST_P;
      end
      ST_P: begin
        p_nxt     = shf_sat;
        state_nxt = ST_MI;
      end
      ST_MI: begin
        mul_a     = time_step_r;
        mul_b     = rerr_r;
        prod_nxt  = $signed(mul_full[PROD_W-1:0]);
        state_nxt = ST_IACC;
      end
      ST_IACC: begin
        // accumulate, then apply the anti-windup clamp
        add_a     = integ_r;
        add_b     = shf_sat;
        clp_in    = add_sat;
        clp_lim   = int_lim_r;
        integ_nxt = clp_out;
        state_nxt = ST_MKI;
      end
      ST_MKI: begin
        mul_a     = int_gain_r;
        mul_b     = integ_r;
        prod_nxt  = $signed(mul_full[PROD_W-1:0]);
        state_nxt = ST_I;
      end
      ST_I: begin
        i_nxt     = shf_sat;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        add_a     = rerr_r;
        add_b     = last_err_r;
        add_sub   = 1'b1;
        x_nxt     = add_sat;
        state_nxt = ST_MD;
      end
      ST_MD: begin
        mul_a     = deriv_gain_r;
        mul_b     = x_r;
        prod_nxt  = $signed(mul_full[PROD_W-1:0]);
        state_nxt = ST_DPROD;
      end
      ST_DPROD: begin
        // load |dprod| << FRAC_W as the dividend; zero time step gives no derivative
        neg_nxt = shf_sat[DATA_W-1];
        quo_nxt = {dmag[DATA_W-1:0], {FRAC_W{1'b0}}};
        rem_nxt = '0;
        cnt_nxt = '0;
        if (time_step_r == '0) begin
          d_nxt     = '0;
          state_nxt = ST_SUM1;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_try[GAIN_W+1]) begin
          rem_nxt = div_try[GAIN_W-1:0];
          quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[GAIN_W-2:0], quo_r[DIV_W-1]};
          quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          state_nxt = ST_DFIN;
        end
      end
      ST_DFIN: begin
        d_nxt     = sat_wide(qsig);
        state_nxt = ST_SUM1;
      end
      ST_SUM1: begin
        add_a     = p_r;
        add_b     = i_r;
        p_nxt     = add_sat;
        state_nxt = ST_SUM2;
      end
      ST_SUM2: begin
        add_a        = p_r;
        add_b        = d_r;
        clp_in       = add_sat;
        clp_lim      = out_lim_r;
        last_out_nxt = clp_out;
        last_err_nxt = rerr_r;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register frees
        if (out_free) begin
          out_cmd_nxt   = last_out_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      last_err_r  <= '0;
      last_out_r  <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      last_err_r  <= last_err_nxt;
      last_out_r  <= last_out_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_r      <= sp_nxt;
    am_r      <= am_nxt;
    rm_r      <= rm_nxt;
    x_r       <= x_nxt;
    rerr_r    <= rerr_nxt;
    p_r       <= p_nxt;
    i_r       <= i_nxt;
    d_r       <= d_nxt;
    prod_r    <= prod_nxt;
    rem_r     <= rem_nxt;
    quo_r     <= quo_nxt;
    neg_r     <= neg_nxt;
    out_cmd_r <= out_cmd_nxt;
  end

  // ---------------------------------------------------------------- assertions
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != ST_IDLE)
    else $error("accepted word did not start the sequencer");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the final step");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> cnt_r <= CNT_W'(DIV_W - 1))
    else $error("divider step count overran");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_clear_state |=>
      integ_r == '0 && last_err_r == '0 && last_out_r == '0)
    else $error("clear word left loop state");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_valid_r && !out_ready |=> state_r == ST_DONE)
    else $error("finished word left the final step while the output was full");

endmodule
`default_nettype wire
